@@ hw/rtl/mh2_pkg.sv @@
package mh2_pkg;

  localparam logic [31:0] MURMUR_MUL = 32'h5bd1e995;
  localparam int unsigned K_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT1 = 13;
  localparam int unsigned FIN_SHIFT2 = 15;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] FULL_BYTES = 3'd4;

  typedef enum logic [1:0] {
    OP_FULL,  // whole word goes through the k mix
    OP_TAIL,  // 1..3 tail bytes, already masked
    OP_NONE   // last item with no bytes
  } op_e;

  typedef struct packed {
    logic [31:0] word;
    op_e         op;
    logic        first;
    logic        last;
    logic [31:0] length;
  } entry_t;

endpackage

@@ hw/rtl/mh2_key_if.sv @@
interface mh2_key_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_word;
  logic [2:0]  valid_bytes;
  logic        first_word;
  logic        last_word;
  logic [31:0] total_length;

  modport source (output valid, key_word, valid_bytes, first_word, last_word, total_length,
                  input ready);
  modport sink (input valid, key_word, valid_bytes, first_word, last_word, total_length,
                output ready);
endinterface

@@ hw/rtl/mh2_hash_if.sv @@
interface mh2_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_hash;

  modport source (output valid, key_hash, input ready);
  modport sink (input valid, key_hash, output ready);
endinterface

@@ hw/rtl/mh2_front.sv @@
module mh2_front (
  mh2_key_if.sink         key_i,
  input  logic            q_full_i,
  output logic            push_o,
  output mh2_pkg::entry_t push_data_o
);

  logic [2:0]  nvalid;
  logic [31:0] tail_mask;
  mh2_pkg::op_e op;

  always_comb begin
    nvalid = (key_i.valid_bytes > mh2_pkg::FULL_BYTES) ? mh2_pkg::FULL_BYTES
                                                       : key_i.valid_bytes;
    unique case (nvalid)
      3'd1:    tail_mask = 32'h0000_00ff;
      3'd2:    tail_mask = 32'h0000_ffff;
      3'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0000_0000;
    endcase
    // any word before the last is mixed whole
    if (!key_i.last_word || nvalid == mh2_pkg::FULL_BYTES) begin
      op = mh2_pkg::OP_FULL;
    end else if (nvalid == 3'd0) begin
      op = mh2_pkg::OP_NONE;
    end else begin
      op = mh2_pkg::OP_TAIL;
    end
  end

  assign key_i.ready = !q_full_i;
  assign push_o      = key_i.valid && !q_full_i;

  always_comb begin
    push_data_o.word   = (op == mh2_pkg::OP_FULL) ? key_i.key_word
                                                  : (key_i.key_word & tail_mask);
    push_data_o.op     = op;
    push_data_o.first  = key_i.first_word;
    push_data_o.last   = key_i.last_word;
    push_data_o.length = key_i.total_length;
  end

endmodule

@@ hw/rtl/mh2_queue.sv @@
module mh2_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mh2_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mh2_pkg::entry_t pop_data_o
);

  localparam int unsigned PtrW = (mh2_pkg::QUEUE_DEPTH > 1) ? $clog2(mh2_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(mh2_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(mh2_pkg::QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] Depth   = CntW'(mh2_pkg::QUEUE_DEPTH);

  mh2_pkg::entry_t slots_q [mh2_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == Depth);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/mh2_back.sv @@
module mh2_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  mh2_pkg::entry_t q_data_i,
  output logic            pop_o,
  mh2_hash_if.source      hash_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_H,
    S_TAIL,
    S_FIN
  } state_e;

  state_e      state_q;
  logic [31:0] h_q;      // running hash lives here between words
  logic [31:0] k_q;
  logic        last_q;
  logic        out_valid_q;
  logic [31:0] out_hash_q;

  logic [31:0] mul_in;
  logic [31:0] prod;
  logic [31:0] fin_mix;

  // one shared multiplier, one product per cycle
  always_comb begin
    unique case (state_q)
      S_K1:    mul_in = k_q;
      S_K2:    mul_in = k_q ^ (k_q >> mh2_pkg::K_SHIFT);
      S_H:     mul_in = h_q;
      S_TAIL:  mul_in = h_q ^ k_q;
      S_FIN:   mul_in = h_q ^ (h_q >> mh2_pkg::FIN_SHIFT1);
      default: mul_in = '0;
    endcase
    prod    = mul_in * mh2_pkg::MURMUR_MUL;
    fin_mix = prod ^ (prod >> mh2_pkg::FIN_SHIFT2);
  end

  assign pop_o           = (state_q == S_IDLE) && q_valid_i;
  assign hash_o.valid    = out_valid_q;
  assign hash_o.key_hash = out_hash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      h_q         <= '0;
      k_q         <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_hash_q  <= '0;
    end else begin
      if (state_q == S_FIN && (!out_valid_q || hash_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (hash_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            h_q    <= q_data_i.first ? q_data_i.length : h_q;
            k_q    <= q_data_i.word;
            last_q <= q_data_i.last;
            unique case (q_data_i.op)
              mh2_pkg::OP_FULL: state_q <= S_K1;
              mh2_pkg::OP_TAIL: state_q <= S_TAIL;
              default:          state_q <= S_FIN;
            endcase
          end
        end
        S_K1: begin
          k_q     <= prod;
          state_q <= S_K2;
        end
        S_K2: begin
          k_q     <= prod;
          state_q <= S_H;
        end
        S_H: begin
          h_q     <= prod ^ k_q;
          state_q <= last_q ? S_FIN : S_IDLE;
        end
        S_TAIL: begin
          h_q     <= prod;
          state_q <= S_FIN;
        end
        S_FIN: begin
          // wait for a free output slot
          if (!out_valid_q || hash_o.ready) begin
            out_hash_q  <= fin_mix;
            h_q         <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/murmur2_hash32_unit.sv @@
// MurmurHash2 32-bit, seed 0. Front classifies words, a 2-entry queue feeds the back end,
// which runs every multiply on one shared 32x32 multiplier, one product per cycle.
// Each non-last word is popped and then run through three multiplies (k, k mix, h). A last
// full word gets the same three and then the final mix, a tail gets the tail mix and then the
// final mix, an empty item goes straight to the final mix; then the hash sits in the output register.
// Reset (async, active low) empties the queue, clears the running hash and the output valid.
module murmur2_hash32_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  mh2_key_if.sink    key_i,
  mh2_hash_if.source hash_o
);

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_valid;
  mh2_pkg::entry_t push_data;
  mh2_pkg::entry_t q_data;

  mh2_front u_front (
    .key_i       (key_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mh2_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  mh2_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .pop_o     (pop),
    .hash_o    (hash_o)
  );

endmodule
